// File: sv/tmac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmac_pkg
// Shared types and constants for the triangle minimum-angle cosine pipeline.
// ----------------------------------------------------------------------------
package tmac_pkg;

  localparam int COORD_BITS = 24;

  // Scaled coordinate differences are 30 bits wide in every configuration.
  localparam int DIFF_W = 30;
  localparam int SHL    = (COORD_BITS <= DIFF_W) ? (DIFF_W - COORD_BITS) : 0;
  localparam int SHR    = (COORD_BITS >  DIFF_W) ? (COORD_BITS - DIFF_W) : 0;

  localparam int SQ_W   = 2 * DIFF_W;      // one squared difference
  localparam int RAD_W  = SQ_W + 2;        // sum of three squares
  localparam int LEN_W  = DIFF_W + 1;      // floor(sqrt(radicand))
  localparam int WIDE_W = 64;              // working width of sqrt and divider

  localparam int SQRT_STEPS = LEN_W + 1;   // one result bit per stage

  localparam int COS_BITS = 15;            // quotient bits, Q1.15
  localparam int COS_W    = 16;
  localparam int COS_LAT  = 4 + COS_BITS + 1;

  localparam logic [COS_W-1:0] COS_MAX = 16'h7FFF;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [LEN_W-1:0]             len_t;
  typedef logic [COS_W-1:0]             cos_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } in_t;

  typedef struct packed {
    logic signed [COS_W-1:0] cos_min_angle;
    logic                    degenerate;
  } out_t;

endpackage

// File: sv/triangle_min_angle_cosine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_min_angle_cosine
// Cosine of the smallest angle of a 3D triangle, Q1.15, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | ports                  | beat taken when
//  ---------+------------------------+--------------------------
//  command  | start, busy, corners   | start high and busy low
//  result   | done, result           | every cycle done is high
//
//  One triangle per clock. busy is always low: the pipeline never stalls.
//  Side lengths take 3 arithmetic stages plus a 32-stage square root, the
//  corner cosines take products, sums, numerator, saturation, a 15-stage
//  divider and select, and then come the maximum and the output register.
//  Synchronous reset clears only the valid bits; data registers are free.
//  The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module triangle_min_angle_cosine (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tmac_pkg::in_t  corners,
  output logic           done,
  output tmac_pkg::out_t result
);

  localparam int CL = tmac_pkg::COS_LAT;

  logic           in_valid;
  logic           v_ab, v_bc, v_ca;
  logic           z_ab, z_bc, z_ca;
  tmac_pkg::len_t l_ab, l_bc, l_ca;

  // never hold off a command beat
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  tmac_side u_side_ab (
    .clk (clk), .rst (rst), .in_valid (in_valid),
    .ux (corners.ax), .uy (corners.ay), .uz (corners.az),
    .vx (corners.bx), .vy (corners.by), .vz (corners.bz),
    .out_valid (v_ab), .len (l_ab), .zero (z_ab)
  );

  tmac_side u_side_bc (
    .clk (clk), .rst (rst), .in_valid (in_valid),
    .ux (corners.bx), .uy (corners.by), .uz (corners.bz),
    .vx (corners.cx), .vy (corners.cy), .vz (corners.cz),
    .out_valid (v_bc), .len (l_bc), .zero (z_bc)
  );

  tmac_side u_side_ca (
    .clk (clk), .rst (rst), .in_valid (in_valid),
    .ux (corners.cx), .uy (corners.cy), .uz (corners.cz),
    .vx (corners.ax), .vy (corners.ay), .vz (corners.az),
    .out_valid (v_ca), .len (l_ca), .zero (z_ca)
  );

  logic           side_valid;
  logic           cv_a, cv_b, cv_c;
  tmac_pkg::cos_t cos_a, cos_b, cos_c;

  // all three side pipelines run in lockstep
  assign side_valid = v_ab && v_bc && v_ca;

  // angle at A: opposite bc
  tmac_cos u_cos_a (
    .clk (clk), .rst (rst), .in_valid (side_valid),
    .s (l_bc), .p (l_ab), .q (l_ca),
    .out_valid (cv_a), .cosine (cos_a)
  );

  // angle at B: opposite ca
  tmac_cos u_cos_b (
    .clk (clk), .rst (rst), .in_valid (side_valid),
    .s (l_ca), .p (l_ab), .q (l_bc),
    .out_valid (cv_b), .cosine (cos_b)
  );

  // angle at C: opposite ab
  tmac_cos u_cos_c (
    .clk (clk), .rst (rst), .in_valid (side_valid),
    .s (l_ab), .p (l_bc), .q (l_ca),
    .out_valid (cv_c), .cosine (cos_c)
  );

  // carry the degenerate flag alongside the cosine pipeline
  logic dq [0:CL];
  assign dq[0] = z_ab || z_bc || z_ca;

  for (genvar g = 0; g < CL; g++) begin : g_deg
    always_ff @(posedge clk) begin
      dq[g+1] <= dq[g];
    end
  end

  // stage 1 of the maximum: first pair, hold the third cosine
  logic           m_valid, m_deg;
  tmac_pkg::cos_t m_ab, m_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      m_valid <= cv_a && cv_b && cv_c;
      done    <= m_valid;
    end
    m_ab  <= (cos_b > cos_a) ? cos_b : cos_a;
    m_c   <= cos_c;
    m_deg <= dq[CL];
    // output register: a degenerate triangle reports zero
    result.degenerate <= m_deg;
    if (m_deg) begin
      result.cos_min_angle <= '0;
    end else begin
      result.cos_min_angle <= (m_c > m_ab) ? m_c : m_ab;
    end
  end

endmodule

// File: sv/tmac_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmac_sqrt
// Pipelined integer square root, one result bit per stage, with a flag beat.
// ----------------------------------------------------------------------------
module tmac_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [tmac_pkg::RAD_W-1:0]     radicand,
  input  logic                           in_flag,
  output logic                           out_valid,
  output tmac_pkg::len_t                 root,
  output logic                           out_flag
);

  localparam int N = tmac_pkg::SQRT_STEPS;
  localparam int W = tmac_pkg::WIDE_W;

  logic [W-1:0] xs   [0:N];
  logic [W-1:0] rs   [0:N];
  logic         vs   [0:N];
  logic         fs   [0:N];

  assign xs[0] = W'(radicand);
  assign rs[0] = '0;
  assign vs[0] = in_valid;
  assign fs[0] = in_flag;

  for (genvar g = 0; g < N; g++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - g));
    logic [W-1:0] trial;
    assign trial = rs[g] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[g+1] <= 1'b0;
      end else begin
        vs[g+1] <= vs[g];
      end
      fs[g+1] <= fs[g];
      if (xs[g] >= trial) begin
        xs[g+1] <= xs[g] - trial;
        rs[g+1] <= (rs[g] >> 1) + BIT;
      end else begin
        xs[g+1] <= xs[g];
        rs[g+1] <= rs[g] >> 1;
      end
    end
  end

  assign out_valid = vs[N];
  assign root      = rs[N][tmac_pkg::LEN_W-1:0];
  assign out_flag  = fs[N];

endmodule

// File: sv/tmac_side.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmac_side
// Side length between two corners: scaled differences, squares, sum, root.
// ----------------------------------------------------------------------------
module tmac_side (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tmac_pkg::coord_t ux,
  input  tmac_pkg::coord_t uy,
  input  tmac_pkg::coord_t uz,
  input  tmac_pkg::coord_t vx,
  input  tmac_pkg::coord_t vy,
  input  tmac_pkg::coord_t vz,
  output logic             out_valid,
  output tmac_pkg::len_t   len,
  output logic             zero
);

  localparam int CB = tmac_pkg::COORD_BITS;
  localparam int DW = tmac_pkg::DIFF_W;
  localparam int SW = tmac_pkg::SQ_W;
  localparam int RW = tmac_pkg::RAD_W;
  localparam int TW = CB + tmac_pkg::SHL;

  function automatic logic [DW-1:0] scaled_abs(input tmac_pkg::coord_t a,
                                                input tmac_pkg::coord_t b);
    logic signed [CB:0] d;
    logic [CB-1:0]      m;
    logic [TW-1:0]      t;
    d = (CB+1)'(a) - (CB+1)'(b);
    m = d[CB] ? CB'(-d) : d[CB-1:0];
    t = TW'(m) << tmac_pkg::SHL;
    return DW'(t >> tmac_pkg::SHR);
  endfunction

  // stage 1: scaled absolute differences
  logic          v1, z1;
  logic [DW-1:0] dx, dy, dz;
  // stage 2: squares
  logic          v2, z2;
  logic [SW-1:0] sx, sy, sz;
  // stage 3: radicand
  logic          v3, z3;
  logic [RW-1:0] rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    dx  <= scaled_abs(ux, vx);
    dy  <= scaled_abs(uy, vy);
    dz  <= scaled_abs(uz, vz);
    z1  <= (ux == vx) && (uy == vy) && (uz == vz);
    sx  <= dx * dx;
    sy  <= dy * dy;
    sz  <= dz * dz;
    z2  <= z1;
    rad <= RW'(sx) + RW'(sy) + RW'(sz);
    z3  <= z2;
  end

  tmac_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .radicand  (rad),
    .in_flag   (z3),
    .out_valid (out_valid),
    .root      (len),
    .out_flag  (zero)
  );

endmodule

// File: sv/tmac_cos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmac_cos
// Law-of-cosines corner cosine in Q1.15 with a pipelined restoring divider.
// ----------------------------------------------------------------------------
module tmac_cos (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  tmac_pkg::len_t s,
  input  tmac_pkg::len_t p,
  input  tmac_pkg::len_t q,
  output logic           out_valid,
  output tmac_pkg::cos_t cosine
);

  localparam int W  = tmac_pkg::WIDE_W;
  localparam int PW = 2 * tmac_pkg::LEN_W;
  localparam int NB = tmac_pkg::COS_BITS;

  // stage A: products
  logic          va;
  logic [PW-1:0] pp, qq, ss, pq;
  // stage B: sums
  logic          vb;
  logic [W-1:0]  sa, sb, den_b;
  // stage C: numerator and early cases
  logic          vc, dz_c, fz_c;
  logic [W-1:0]  num_c, den_c;
  // stage D: saturation
  logic          vd, fmax_d, fzero_d;
  logic [W-1:0]  num_d, den_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
    pp      <= p * p;
    qq      <= q * q;
    ss      <= s * s;
    pq      <= p * q;
    sa      <= W'(pp) + W'(qq);
    sb      <= W'(ss);
    den_b   <= W'(pq) << 1;
    dz_c    <= (den_b == '0);
    fz_c    <= (sa <= sb);
    num_c   <= sa - sb;
    den_c   <= den_b;
    fmax_d  <= dz_c || (!fz_c && (num_c >= den_c));
    fzero_d <= !dz_c && fz_c;
    num_d   <= num_c;
    den_d   <= den_c;
  end

  // divider: one quotient bit per stage
  logic [W-1:0]  rem  [0:NB];
  logic [W-1:0]  dv   [0:NB];
  logic [NB-1:0] quo  [0:NB];
  logic          vv   [0:NB];
  logic          fm   [0:NB];
  logic          fz   [0:NB];

  assign rem[0] = num_d;
  assign dv[0]  = den_d;
  assign quo[0] = '0;
  assign vv[0]  = vd;
  assign fm[0]  = fmax_d;
  assign fz[0]  = fzero_d;

  for (genvar g = 0; g < NB; g++) begin : g_div
    logic [W-1:0] sh;
    assign sh = rem[g] << 1;

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[g+1] <= 1'b0;
      end else begin
        vv[g+1] <= vv[g];
      end
      dv[g+1] <= dv[g];
      fm[g+1] <= fm[g];
      fz[g+1] <= fz[g];
      if (sh >= dv[g]) begin
        rem[g+1] <= sh - dv[g];
        quo[g+1] <= {quo[g][NB-2:0], 1'b1};
      end else begin
        rem[g+1] <= sh;
        quo[g+1] <= {quo[g][NB-2:0], 1'b0};
      end
    end
  end

  // final select
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vv[NB];
    end
    if (fm[NB]) begin
      cosine <= tmac_pkg::COS_MAX;
    end else if (fz[NB]) begin
      cosine <= '0;
    end else begin
      cosine <= tmac_pkg::COS_W'(quo[NB]);
    end
  end

endmodule

// File: verif/triangle_min_angle_cosine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_min_angle_cosine_tb
// Self-checking bench for the triangle minimum-angle cosine pipeline. Feeds a
// table of directed triangles followed by random ones, predicts every result
// with a bit-exact integer model (side lengths by integer square root, law
// of cosines by restoring division), and compares each done beat in order.
// ----------------------------------------------------------------------------
module triangle_min_angle_cosine_tb;

  localparam int  LATENCY  = 60;        // covers the pipeline depth, with margin
  localparam int  N_RANDOM = 1000;
  localparam longint CYCLE_LIMIT = 200000;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  tmac_pkg::in_t   corners;
  logic            done;
  tmac_pkg::out_t  result;

  triangle_min_angle_cosine u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .corners (corners),
    .done    (done),
    .result  (result)
  );

  // Expected results, oldest first.
  tmac_pkg::out_t cos_expected_q[$];
  int             errors;
  longint         cycles;
  int             send_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Floor square root of a radicand below 2^62.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Absolute difference scaled to the 30-bit working range.
  function automatic longint unsigned scaled_diff(tmac_pkg::coord_t a,
                                                  tmac_pkg::coord_t b);
    longint signed   sa;
    longint signed   sb;
    longint unsigned u;
    sa = a;
    sb = b;
    u  = (sa >= sb) ? longint'(sa - sb) : longint'(sb - sa);
    return (u << tmac_pkg::SHL) >> tmac_pkg::SHR;
  endfunction

  function automatic longint unsigned side_length(
      tmac_pkg::coord_t ux, tmac_pkg::coord_t uy, tmac_pkg::coord_t uz,
      tmac_pkg::coord_t vx, tmac_pkg::coord_t vy, tmac_pkg::coord_t vz);
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned dz;
    dx = scaled_diff(ux, vx);
    dy = scaled_diff(uy, vy);
    dz = scaled_diff(uz, vz);
    return int_sqrt(dx * dx + dy * dy + dz * dz);
  endfunction

  // Cosine in Q1.15 of the angle opposite s, between sides p and q.
  function automatic longint unsigned angle_cosine(longint unsigned s,
                                                   longint unsigned p,
                                                   longint unsigned q);
    longint unsigned a;
    longint unsigned b;
    longint unsigned den;
    longint unsigned rem;
    longint unsigned quo;
    a   = p * p + q * q;
    b   = s * s;
    den = 2 * p * q;
    quo = 0;
    if (den == 0) return 32767;
    if (a <= b) return 0;
    rem = a - b;
    if (rem >= den) return 32767;
    for (int i = 0; i < tmac_pkg::COS_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 1;
      end
    end
    return quo;
  endfunction

  function automatic tmac_pkg::out_t min_angle_cosine(tmac_pkg::in_t t);
    tmac_pkg::out_t  r;
    longint unsigned ab;
    longint unsigned bc;
    longint unsigned ca;
    longint unsigned best;
    longint unsigned c;
    r = '0;
    if ((t.ax == t.bx && t.ay == t.by && t.az == t.bz) ||
        (t.bx == t.cx && t.by == t.cy && t.bz == t.cz) ||
        (t.cx == t.ax && t.cy == t.ay && t.cz == t.az)) begin
      r.degenerate = 1'b1;
      return r;
    end
    ab   = side_length(t.ax, t.ay, t.az, t.bx, t.by, t.bz);
    bc   = side_length(t.bx, t.by, t.bz, t.cx, t.cy, t.cz);
    ca   = side_length(t.cx, t.cy, t.cz, t.ax, t.ay, t.az);
    best = angle_cosine(bc, ab, ca);
    c    = angle_cosine(ca, ab, bc);
    if (c > best) best = c;
    c    = angle_cosine(ab, bc, ca);
    if (c > best) best = c;
    r.cos_min_angle = best[tmac_pkg::COS_W-1:0];
    return r;
  endfunction

  // Send one triangle: hold start until the beat is taken, idling first
  // at random. Inputs move only on the falling edge.
  task automatic send_triangle(tmac_pkg::in_t t, logic has_hint, tmac_pkg::out_t hint);
    tmac_pkg::out_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    corners <= t;
    e = min_angle_cosine(t);
    if (has_hint && e !== hint) begin
      $display("%0t: predictor disagrees with table: expected %h got %h",
               $time, hint, e);
      errors++;
    end
    @(posedge clk);
    while (busy) @(posedge clk);
    cos_expected_q.insert(cos_expected_q.size(), e);
    @(negedge clk);
  endtask

  function automatic tmac_pkg::coord_t rand_coord(int mode);
    case (mode)
      0:       return tmac_pkg::coord_t'($urandom);
      1:       return tmac_pkg::coord_t'(int'($urandom_range(0, 15)) - 8);
      default: return tmac_pkg::coord_t'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  // Directed triangles; expected value typed in only where obvious.
  typedef struct {
    tmac_pkg::in_t  shape;
    logic           has_hint;
    tmac_pkg::out_t hint;
  } dir_row_t;

  localparam tmac_pkg::coord_t CMAX = {1'b0, {(tmac_pkg::COORD_BITS-1){1'b1}}};
  localparam tmac_pkg::coord_t CMIN = {1'b1, {(tmac_pkg::COORD_BITS-1){1'b0}}};

  dir_row_t dir_rows[$];

  function automatic tmac_pkg::in_t mk(
      tmac_pkg::coord_t ax, tmac_pkg::coord_t ay, tmac_pkg::coord_t az,
      tmac_pkg::coord_t bx, tmac_pkg::coord_t by, tmac_pkg::coord_t bz,
      tmac_pkg::coord_t cx, tmac_pkg::coord_t cy, tmac_pkg::coord_t cz);
    tmac_pkg::in_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    return t;
  endfunction

  // Append one directed row to the table.
  function automatic void add_row(tmac_pkg::in_t shape, logic has_hint,
                                  tmac_pkg::out_t hint);
    dir_row_t row;
    row = '{shape, has_hint, hint};
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Check every done beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (cos_expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        tmac_pkg::out_t e;
        e = cos_expected_q.pop_front();
        if (result.cos_min_angle !== e.cos_min_angle) begin
          $display("%0t: cos_min_angle expected %0d got %0d",
                   $time, e.cos_min_angle, result.cos_min_angle);
          errors++;
        end
        if (result.degenerate !== e.degenerate) begin
          $display("%0t: degenerate expected %0b got %0b",
                   $time, e.degenerate, result.degenerate);
          errors++;
        end
      end
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_min_angle_cosine regression: fail");
      $finish;
    end
  end

  initial begin
    tmac_pkg::out_t deg;
    tmac_pkg::out_t one;
    tmac_pkg::out_t zero_hint;
    tmac_pkg::in_t  t;
    int             mode;
    errors        = 0;
    cycles        = 0;
    send_idle_pct = 0;
    rst     = 1'b1;
    start   = 1'b0;
    corners = '0;
    deg     = '{cos_min_angle: '0, degenerate: 1'b1};
    one     = '{cos_min_angle: tmac_pkg::COS_MAX, degenerate: 1'b0};
    zero_hint = '0;

    // Degenerate: coincident corners on each side.
    add_row(mk(0,0,0, 0,0,0, 0,0,0), 1'b1, deg);
    add_row(mk(5,6,7, 5,6,7, 1,2,3), 1'b1, deg);
    add_row(mk(1,2,3, 5,6,7, 5,6,7), 1'b1, deg);
    add_row(mk(CMAX,CMIN,CMAX, 0,0,0, CMAX,CMIN,CMAX), 1'b1, deg);
    // Collinear: smallest angle is zero, cosine saturates.
    add_row(mk(0,0,0, 256,0,0, 512,0,0), 1'b1, one);
    add_row(mk(CMIN,CMIN,CMIN, 0,0,0, CMAX,CMAX,CMAX), 1'b0, zero_hint);
    // Extremes of every coordinate.
    add_row(mk(CMIN,CMIN,CMIN, CMAX,CMAX,CMAX, CMIN,CMAX,CMIN), 1'b0, zero_hint);
    add_row(mk(CMAX,CMIN,CMAX, CMIN,CMAX,CMIN, CMAX,CMAX,CMAX), 1'b0, zero_hint);
    add_row(mk(CMAX,0,0, 0,CMAX,0, 0,0,CMAX), 1'b0, zero_hint);
    add_row(mk(CMIN,0,0, 0,CMIN,0, 0,0,CMIN), 1'b0, zero_hint);
    // Equilateral-ish, right angle, obtuse, tiny sides.
    add_row(mk(0,0,0, 1,0,0, 0,1,0), 1'b0, zero_hint);
    add_row(mk(1,0,0, 0,1,0, 0,0,1), 1'b0, zero_hint);
    add_row(mk(0,0,0, 4096,0,0, 2048,3547,0), 1'b0, zero_hint);
    add_row(mk(0,0,0, 1000,0,0, 500,1,0), 1'b0, zero_hint);
    add_row(mk(-1,-1,-1, 1,1,1, -1,1,-1), 1'b0, zero_hint);
    // Long thin sliver: cosine close to one.
    add_row(mk(0,0,0, CMAX,0,0, 0,1,0), 1'b0, zero_hint);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      send_triangle(dir_rows[i].shape, dir_rows[i].has_hint, dir_rows[i].hint);

    // Hold off until the pipeline has drained everything.
    start <= 1'b0;
    while (cos_expected_q.size() != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      // Sender idles 20% in the first third; in the rest 84% and then none.
      send_idle_pct = (n < N_RANDOM / 3) ? 20 : (n < 2 * N_RANDOM / 3) ? 84 : 0;
      mode = $urandom_range(0, 2);
      t = mk(rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode));
      // Now and then, share a corner to hit degenerate triangles.
      if ($urandom_range(0, 19) == 0) begin
        t.cx = t.ax;
        t.cy = t.ay;
        t.cz = t.az;
      end
      send_triangle(t, 1'b0, zero_hint);
    end
    start <= 1'b0;

    while (cos_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);

    if (errors == 0)
      $display("triangle_min_angle_cosine regression: pass");
    else
      $display("triangle_min_angle_cosine regression: fail");
    $finish;
  end

endmodule
